// File: rtl/mpq_pkg.sv
// Package for the minimum priority queue: widths, default depth, codes and
// the entry and command types that the top level and its cells share.
// No dependencies.
`timescale 1ns / 1ps

package mpq_pkg;

	// Default number of cells in the chain.
	localparam int QUEUE_DEPTH_DEF = 16;

	// Fixed field widths.
	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;

	// Operation codes carried on the action field.
	localparam logic ACTION_PUSH = 1'b0;
	localparam logic ACTION_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// One stored entry.
	typedef struct packed {
		logic [DATA_W-1:0]        data;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	// Command broadcast to every cell in the cycle that a transaction is accepted.
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t item;
	} cell_cmd_t;

endpackage

// File: rtl/mpq_cell.sv
// One cell of the sorted chain: holds an entry and its arrival age.
// Depends on mpq_pkg for the entry and command types.
`timescale 1ns / 1ps

module mpq_cell #(
	parameter int AGE_W = $clog2(mpq_pkg::QUEUE_DEPTH_DEF)
) (
	input  logic                  clk,
	input  mpq_pkg::cell_cmd_t    cmd,
	input  logic [AGE_W-1:0]      new_age,
	input  logic [AGE_W-1:0]      removed_age,
	input  logic                  valid,
	input  logic                  tail,
	input  logic                  left_gt,
	input  mpq_pkg::entry_t       left_entry,
	input  logic [AGE_W-1:0]      left_age,
	input  mpq_pkg::entry_t       right_entry,
	input  logic [AGE_W-1:0]      right_age,
	output mpq_pkg::entry_t       entry,
	output logic [AGE_W-1:0]      age,
	output logic                  gt
);

	mpq_pkg::entry_t  entry_q;
	logic [AGE_W-1:0] age_q;
	logic [AGE_W-1:0] right_age_adj;

	// A held entry yields its place to a new one of strictly smaller priority,
	// so equal priorities stay in arrival order.
	assign gt = valid && (cmd.item.prio < entry_q.prio);

	// Ages above the removed one close up by one.
	assign right_age_adj = (right_age > removed_age) ? right_age - 1'b1 : right_age;

	// Push shifts the larger entries right; pop shifts everything left.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (left_gt) begin
				entry_q <= left_entry;
				age_q   <= left_age;
			end else if (gt || tail) begin
				entry_q <= cmd.item;
				age_q   <= new_age;
			end
		end else if (cmd.pop) begin
			entry_q <= right_entry;
			age_q   <= right_age_adj;
		end
	end

	assign entry = entry_q;
	assign age   = age_q;

endmodule

// File: rtl/min_priority_queue.sv
// Top level of the minimum priority queue: control, count and the cell chain.
// Depends on mpq_pkg and mpq_cell.
//
// Usage: an input transaction carries action, data_in and priority_in. A push
// stores the word with its signed priority; a pop removes the entry with the
// smallest priority, the oldest of equals, and returns its data. Every input
// transaction gives exactly one output transaction with the popped data, a
// status (ok, pop on empty, push on full), the count held afterwards, an
// empty flag and the data of the oldest entry held.
// The cells keep entries sorted by priority and tag each with its arrival age,
// so the minimum always sits in the first cell and the oldest entry is the
// one whose age is zero.
// The chain and the staging register load in the accepting cycle, and the
// result register loads from the one-deep staging register once the output is
// free; no new input transaction is taken until the staged one has moved on.
// A finished result may wait on out_stall while the next item is taken; the
// input then stalls until the output register frees.
// Reset empties the queue at once; cell contents are not cleared.
`timescale 1ns / 1ps

module min_priority_queue #(
	parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF,
	localparam int AGE_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [mpq_pkg::DATA_W-1:0]        data_in,
	input  logic signed [mpq_pkg::PRIO_W-1:0] priority_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mpq_pkg::DATA_W-1:0]        data_out,
	output logic [1:0]                        status,
	output logic [CNT_W-1:0]                  entry_count,
	output logic                              queue_empty,
	output logic [mpq_pkg::DATA_W-1:0]        oldest_data
);

	logic                       accept;
	logic                       advance;
	logic                       is_pop;
	logic                       is_full;
	logic                       is_empty;
	mpq_pkg::status_t           status_next;
	mpq_pkg::cell_cmd_t         cmd;
	logic [CNT_W-1:0]           held_count_q;
	logic                       pend_q;
	mpq_pkg::status_t           pend_status_q;
	logic [mpq_pkg::DATA_W-1:0] pend_data_q;
	logic                       out_valid_q;
	mpq_pkg::status_t           out_status_q;
	logic [mpq_pkg::DATA_W-1:0] out_data_q;
	logic [CNT_W-1:0]           out_count_q;
	logic [mpq_pkg::DATA_W-1:0] out_oldest_q;
	logic [mpq_pkg::DATA_W-1:0] oldest_sel;

	mpq_pkg::entry_t            cell_entry [QUEUE_DEPTH];
	logic [AGE_W-1:0]           cell_age   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]     cell_gt;
	logic [QUEUE_DEPTH-1:0]     cell_valid;
	logic [QUEUE_DEPTH-1:0]     cell_tail;

	// Handshake and decode of the incoming transaction.
	assign in_stall = pend_q;
	assign accept   = in_valid && !pend_q;
	assign advance  = pend_q && (!out_valid_q || !out_stall);
	assign is_pop   = (action == mpq_pkg::ACTION_POP);
	assign is_full  = (held_count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (held_count_q == '0);

	always_comb begin
		if (is_pop && is_empty) begin
			status_next = mpq_pkg::STATUS_EMPTY;
		end else if (!is_pop && is_full) begin
			status_next = mpq_pkg::STATUS_FULL;
		end else begin
			status_next = mpq_pkg::STATUS_OK;
		end
	end

	// Command broadcast to the chain; only a successful operation moves cells.
	assign cmd.push      = accept && !is_pop && !is_full;
	assign cmd.pop       = accept && is_pop && !is_empty;
	assign cmd.item.data = data_in;
	assign cmd.item.prio = priority_in;

	// The chain of cells.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam int L = (i == 0) ? 0 : i - 1;
		localparam int R = (i == QUEUE_DEPTH - 1) ? i : i + 1;

		assign cell_valid[i] = (held_count_q > CNT_W'(i));
		assign cell_tail[i]  = (held_count_q == CNT_W'(i));

		mpq_cell #(
			.AGE_W(AGE_W)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.new_age     (held_count_q[AGE_W-1:0]),
			.removed_age (cell_age[0]),
			.valid       (cell_valid[i]),
			.tail        (cell_tail[i]),
			.left_gt     ((i == 0) ? 1'b0 : cell_gt[L]),
			.left_entry  (cell_entry[L]),
			.left_age    (cell_age[L]),
			.right_entry (cell_entry[R]),
			.right_age   (cell_age[R]),
			.entry       (cell_entry[i]),
			.age         (cell_age[i]),
			.gt          (cell_gt[i])
		);
	end

	// Pick the data of the held entry whose age is zero.
	always_comb begin
		oldest_sel = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cell_valid[i] && (cell_age[i] == '0)) begin
				oldest_sel = oldest_sel | cell_entry[i].data;
			end
		end
	end

	// Fill count and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.push) begin
				held_count_q <= held_count_q + 1'b1;
			end else if (cmd.pop) begin
				held_count_q <= held_count_q - 1'b1;
			end
			if (accept) begin
				pend_q <= 1'b1;
			end else if (advance) begin
				pend_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Staging and output payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_status_q <= status_next;
			pend_data_q   <= cmd.pop ? cell_entry[0].data : '0;
		end
		if (advance) begin
			out_status_q <= pend_status_q;
			out_data_q   <= pend_data_q;
			out_count_q  <= held_count_q;
			out_oldest_q <= oldest_sel;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_out    = out_data_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;
	assign queue_empty = (out_count_q == '0);
	assign oldest_data = out_oldest_q;

endmodule

// File: rtl/mpq_checker.sv
// Port-level checks for the minimum priority queue, bound to the top level.
// Depends on mpq_pkg and min_priority_queue.
`timescale 1ns / 1ps

module mpq_checker #(
	parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [mpq_pkg::DATA_W-1:0] data_out,
	input logic [1:0]                 status,
	input logic [CNT_W-1:0]           entry_count,
	input logic                       queue_empty,
	input logic [mpq_pkg::DATA_W-1:0] oldest_data
);

	// A stalled result transaction holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(entry_count))
	else $error("stalled result changed");

	// The empty flag agrees with the count, and an empty queue has no oldest data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (queue_empty == (entry_count == '0))
			&& (!queue_empty || oldest_data == '0))
	else $error("empty flag or oldest data inconsistent");

	// A refused operation returns no data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != mpq_pkg::STATUS_OK) |-> data_out == '0)
	else $error("error result carries data");

	// Error codes agree with the count.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != mpq_pkg::STATUS_EMPTY || entry_count == '0)
			&& (status != mpq_pkg::STATUS_FULL || entry_count == CNT_W'(QUEUE_DEPTH)))
	else $error("status disagrees with count");

	// The count never exceeds the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(QUEUE_DEPTH))
	else $error("count beyond depth");

endmodule

bind min_priority_queue mpq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_mpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.data_out    (data_out),
	.status      (status),
	.entry_count (entry_count),
	.queue_empty (queue_empty),
	.oldest_data (oldest_data)
);

// File: tb/sv/mpq_result_checker.sv
// Result checker for the minimum priority queue: watches both channels,
// predicts every result and compares it with what the queue returns.
// Depends on mpq_pkg.
`timescale 1ns / 1ps

module mpq_result_checker #(
	parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              action,
	input  logic [mpq_pkg::DATA_W-1:0]        data_in,
	input  logic signed [mpq_pkg::PRIO_W-1:0] priority_in,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [mpq_pkg::DATA_W-1:0]        data_out,
	input  logic [1:0]                        status,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  entry_count,
	input  logic                              queue_empty,
	input  logic [mpq_pkg::DATA_W-1:0]        oldest_data,
	output int                                fail_count,
	output int                                pending
);

	localparam int DATA_W = mpq_pkg::DATA_W;
	localparam int PRIO_W = mpq_pkg::PRIO_W;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [DATA_W-1:0] data;
		mpq_pkg::status_t  status;
		logic [CNT_W-1:0]  count;
		logic              empty;
		logic [DATA_W-1:0] oldest;
	} queue_result_t;

	// Shadow copy of the queue, kept in arrival order.
	logic [DATA_W-1:0]        model_data [QUEUE_DEPTH];
	logic signed [PRIO_W-1:0] model_prio [QUEUE_DEPTH];
	int                       model_count;
	queue_result_t            pending_results [$];
	int                       errors = 0;

	assign fail_count = errors;

	// Applies one input transaction to the shadow queue and works out its result.
	task automatic predict_queue_result(input logic act, input logic [DATA_W-1:0] word,
			input logic signed [PRIO_W-1:0] prio, output queue_result_t res);
		int best;
		res = '0;
		res.status = mpq_pkg::STATUS_OK;
		if (act == mpq_pkg::ACTION_PUSH) begin
			if (model_count >= QUEUE_DEPTH) begin
				res.status = mpq_pkg::STATUS_FULL;
			end else begin
				model_data[model_count] = word;
				model_prio[model_count] = prio;
				model_count++;
			end
		end else if (model_count == 0) begin
			res.status = mpq_pkg::STATUS_EMPTY;
		end else begin
			// Strict comparison keeps the oldest of equal priorities.
			best = 0;
			for (int i = 1; i < model_count; i++) begin
				if (model_prio[i] < model_prio[best])
					best = i;
			end
			res.data = model_data[best];
			for (int i = best; i < model_count - 1; i++) begin
				model_data[i] = model_data[i + 1];
				model_prio[i] = model_prio[i + 1];
			end
			model_count--;
		end
		res.count  = CNT_W'(model_count);
		res.empty  = (model_count == 0);
		res.oldest = (model_count == 0) ? '0 : model_data[0];
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Input transactions are predicted first, so a result taken at the same edge
	// still pairs with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		queue_result_t res;
		queue_result_t want;
		if (!arst_n) begin
			model_count = 0;
			pending_results.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_queue_result(action, data_in, priority_in, res);
				pending_results.push_back(res);
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result transaction with none expected, data_out %h",
						$time, data_out);
				end else begin
					want = pending_results.pop_front();
					check_field("data_out", want.data, data_out);
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("entry_count", DATA_W'(want.count), DATA_W'(entry_count));
					check_field("queue_empty", DATA_W'(want.empty), DATA_W'(queue_empty));
					check_field("oldest_data", want.oldest, oldest_data);
				end
			end
			pending <= pending_results.size();
		end
	end

endmodule

// File: tb/sv/tb_min_priority_queue.sv
// Testbench top for the minimum priority queue: clock, reset, stimulus and
// the final verdict. Depends on mpq_pkg, min_priority_queue and mpq_result_checker.
`timescale 1ns / 1ps

module tb_min_priority_queue;

	localparam int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF;
	localparam int DATA_W      = mpq_pkg::DATA_W;
	localparam int PRIO_W      = mpq_pkg::PRIO_W;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int QUIET_LIMIT = 2000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     action;
	logic [DATA_W-1:0]        data_in;
	logic signed [PRIO_W-1:0] priority_in;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [DATA_W-1:0]        data_out;
	logic [1:0]               status;
	logic [CNT_W-1:0]         entry_count;
	logic                     queue_empty;
	logic [DATA_W-1:0]        oldest_data;
	int                       fail_count;
	int                       pending;
	int                       idle_pct = 0;
	int                       stall_pct = 0;

	min_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .data_in(data_in), .priority_in(priority_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.data_out(data_out), .status(status), .entry_count(entry_count),
		.queue_empty(queue_empty), .oldest_data(oldest_data)
	);

	mpq_result_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_result_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .data_in(data_in), .priority_in(priority_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.data_out(data_out), .status(status), .entry_count(entry_count),
		.queue_empty(queue_empty), .oldest_data(oldest_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver stalls at random with the current percentage.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Ends the run when no transaction moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("min_priority_queue verification failed");
		$finish;
	end

	// Offers one input transaction after a random gap and holds it until taken.
	task automatic send_request(input logic act, input logic [DATA_W-1:0] word,
			input logic signed [PRIO_W-1:0] prio);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		data_in     <= word;
		priority_in <= prio;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Holds the sender off until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Narrow ranges give many ties; the extremes turn up now and then.
	function automatic logic signed [PRIO_W-1:0] pick_priority();
		case ($urandom_range(9))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2, 3, 4: return PRIO_W'($urandom_range(3));
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int phase_idle [4];
		int phase_stall [4];
		int push_pct;
		bit calm_block;
		phase_idle  = '{0, 74, 0, 36};
		phase_stall = '{0, 0, 74, 36};
		in_valid    = 1'b0;
		action      = mpq_pkg::ACTION_PUSH;
		data_in     = '0;
		priority_in = '0;
		arst_n      = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: pop on empty, field extremes, ties, push on full, pops.
		send_request(mpq_pkg::ACTION_POP, 32'hFFFF_FFFF, 16'sh7FFF);
		send_request(mpq_pkg::ACTION_PUSH, 32'hFFFF_FFFF, 16'sh7FFF);
		send_request(mpq_pkg::ACTION_PUSH, 32'h0000_0000, 16'sh8000);
		send_request(mpq_pkg::ACTION_PUSH, 32'hA5A5_A5A5, 16'sh0000);
		send_request(mpq_pkg::ACTION_PUSH, 32'h5A5A_5A5A, 16'shFFFF);
		for (int k = 0; k < QUEUE_DEPTH - 4; k++)
			send_request(mpq_pkg::ACTION_PUSH, 32'h1000_0000 + k,
				(k % 3 == 0) ? 16'sh8000 : 16'sd7);
		send_request(mpq_pkg::ACTION_PUSH, 32'hDEAD_BEEF, 16'sh0000);
		repeat (5) send_request(mpq_pkg::ACTION_POP, 32'h0000_0000, 16'sh0000);
		wait_drained();

		// Random part: four phases with their own idle and stall rates, each in blocks with their own push rate.
		for (int phase = 0; phase < 4; phase++) begin
			for (int blk = 0; blk < 10; blk++) begin
				case ($urandom_range(3))
					0:       push_pct = 85;
					1:       push_pct = 15;
					default: push_pct = 50;
				endcase
				calm_block = ($urandom_range(3) == 0);
				idle_pct   = calm_block ? 0 : phase_idle[phase];
				stall_pct  = calm_block ? 0 : phase_stall[phase];
				repeat (30)
					send_request(($urandom_range(99) < push_pct) ?
						mpq_pkg::ACTION_PUSH : mpq_pkg::ACTION_POP,
						$urandom, pick_priority());
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("min_priority_queue verification clean");
		else
			$display("min_priority_queue verification failed");
		$finish;
	end

endmodule
